### rtl/core/pmf_pkg.sv
// Shared types and constants for the PUBLISH packet framer.
// No dependencies; the front, queue, back and top files of the framer import this package.
package pmf_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_CTRL_TYPE        = 2'd0;
  localparam logic [1:0] REG_MAX_PACKET_BYTES = 2'd1;

  // Register reset values
  localparam logic [3:0]  CTRL_TYPE_RESET = 4'd3;
  localparam logic [17:0] MAX_BYTES_RESET = 18'd512;

  // Request kinds
  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_BODY   = 1'b1;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TOO_BIG = 1'b1;

  // Largest number of bytes one request can cause
  localparam int ENTRY_BYTES = 8;
  localparam int BIDX_W      = $clog2(ENTRY_BYTES);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified request: the bytes it emits and how to mark them
  typedef struct packed {
    logic [ENTRY_BYTES-1:0][7:0] data;
    logic [BIDX_W-1:0]           last_idx;
    logic                        mark_last;
    logic                        status;
  } entry_t;

  // Queue fill status seen by the front and the checks
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

### rtl/core/pmf_req_if.sv
// Request channel of the framer: header items and body bytes.
// Depends on nothing.
interface pmf_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] topic_size;
  logic [15:0] payload_size;
  logic [15:0] pkt_id;
  logic [1:0]  qos;
  logic        retain;
  logic        dup;
  logic [7:0]  data_byte;

  modport source (output valid, req_type, topic_size, payload_size, pkt_id, qos, retain,
                  dup, data_byte, input ready);
  modport sink (input valid, req_type, topic_size, payload_size, pkt_id, qos, retain,
                dup, data_byte, output ready);
endinterface

### rtl/core/pmf_rsp_if.sv
// Result channel of the framer: one packet byte per result.
// Depends on nothing.
interface pmf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       status;

  modport source (output valid, out_byte, last, status, input ready);
  modport sink (input valid, out_byte, last, status, output ready);
endinterface

### rtl/core/pmf_cfg_if.sv
// Configuration write channel of the framer.
// Depends on nothing.
interface pmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [17:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/pmf_front.sv
// Front end: holds configuration and packet progress, classifies each request
// and builds the byte entry it causes. Depends on pmf_pkg, pmf_req_if, pmf_cfg_if.
module pmf_front (
  input  logic            clk,
  input  logic            rst,
  pmf_req_if.sink         req,
  pmf_cfg_if.sink         cfg,
  input  logic            q_full,
  output logic            push,
  output pmf_pkg::entry_t push_entry
);
  import pmf_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_TOPIC   = 2'd1;
  localparam logic [1:0] PH_MESSAGE = 2'd2;

  logic [3:0]  ctrl_type;
  logic [17:0] max_packet_bytes;
  logic [1:0]  phase, phase_next;
  logic [15:0] topic_left, topic_left_next;
  logic [15:0] message_left, message_left_next;
  logic [15:0] held_id, held_id_next;
  logic        id_pending, id_pending_next;

  logic        accept;
  logic [16:0] len_sum;
  logic [17:0] rem;
  logic [17:0] total;
  logic [1:0]  nlen;
  logic        qos_nz;
  logic        too_big;
  logic [BIDX_W-1:0] k;
  entry_t      e;

  assign cfg.ready = 1'b1;
  assign req.ready = !q_full;
  assign accept    = req.valid && req.ready;

  // Size of the packet a header request describes
  assign qos_nz  = (req.qos != 2'd0);
  assign len_sum = {1'b0, req.topic_size} + {1'b0, req.payload_size};
  assign rem     = {1'b0, len_sum} + (qos_nz ? 18'd4 : 18'd2);
  assign nlen    = (rem < 18'd128) ? 2'd1 : ((rem < 18'd16384) ? 2'd2 : 2'd3);
  assign total   = rem + {16'd0, nlen} + 18'd1;
  assign too_big = (total > max_packet_bytes);

  // Classify the request and build its byte entry
  always_comb begin
    k                 = BIDX_W'(nlen) + BIDX_W'(1);
    e                 = '0;
    push              = 1'b0;
    phase_next        = phase;
    topic_left_next   = topic_left;
    message_left_next = message_left;
    held_id_next      = held_id;
    id_pending_next   = id_pending;
    e.status          = STATUS_OK;
    if (accept) begin
      if (req.req_type == REQ_HEADER) begin
        push = 1'b1;
        if (too_big) begin
          e.last_idx        = '0;
          e.mark_last       = 1'b1;
          e.status          = STATUS_TOO_BIG;
          phase_next        = PH_IDLE;
          topic_left_next   = '0;
          message_left_next = '0;
          id_pending_next   = 1'b0;
        end else begin
          e.data[0] = {ctrl_type, req.dup, req.qos, req.retain};
          e.data[1] = {(nlen != 2'd1), rem[6:0]};
          e.data[2] = {(nlen == 2'd3), rem[13:7]};
          e.data[3] = {4'd0, rem[17:14]};
          e.data[k]          = req.topic_size[15:8];
          e.data[k + 3'd1]   = req.topic_size[7:0];
          e.last_idx         = k + 3'd1;
          topic_left_next    = req.topic_size;
          message_left_next  = req.payload_size;
          held_id_next       = req.pkt_id;
          id_pending_next    = qos_nz;
          if (req.topic_size == 16'd0) begin
            if (qos_nz) begin
              e.data[k + 3'd2] = req.pkt_id[15:8];
              e.data[k + 3'd3] = req.pkt_id[7:0];
              e.last_idx       = k + 3'd3;
            end
            id_pending_next = 1'b0;
            e.mark_last     = (req.payload_size == 16'd0);
            phase_next      = (req.payload_size == 16'd0) ? PH_IDLE : PH_MESSAGE;
          end else begin
            phase_next = PH_TOPIC;
          end
        end
      end else begin
        unique case (phase)
          PH_TOPIC: begin
            push            = 1'b1;
            e.data[0]       = req.data_byte;
            topic_left_next = topic_left - 16'd1;
            if (topic_left == 16'd1) begin
              if (id_pending) begin
                e.data[1]  = held_id[15:8];
                e.data[2]  = held_id[7:0];
                e.last_idx = 3'd2;
              end
              id_pending_next = 1'b0;
              e.mark_last     = (message_left == 16'd0);
              phase_next      = (message_left == 16'd0) ? PH_IDLE : PH_MESSAGE;
            end
          end
          PH_MESSAGE: begin
            push              = 1'b1;
            e.data[0]         = req.data_byte;
            message_left_next = message_left - 16'd1;
            if (message_left == 16'd1) begin
              e.mark_last = 1'b1;
              phase_next  = PH_IDLE;
            end
          end
          default: begin
            // drop body bytes that arrive outside a packet
            push = 1'b0;
          end
        endcase
      end
    end
  end

  assign push_entry = e;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_type        <= CTRL_TYPE_RESET;
      max_packet_bytes <= MAX_BYTES_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_CTRL_TYPE:        ctrl_type        <= cfg.data[3:0];
        REG_MAX_PACKET_BYTES: max_packet_bytes <= cfg.data;
        default: ;
      endcase
    end
  end

  // Advance packet progress
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      topic_left   <= '0;
      message_left <= '0;
      held_id      <= '0;
      id_pending   <= 1'b0;
    end else begin
      phase        <= phase_next;
      topic_left   <= topic_left_next;
      message_left <= message_left_next;
      held_id      <= held_id_next;
      id_pending   <= id_pending_next;
    end
  end

endmodule

### rtl/core/pmf_queue.sv
// Short queue of byte entries between the front and back ends.
// Depends on pmf_pkg.
module pmf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pmf_pkg::entry_t  push_entry,
  input  logic             pop,
  output pmf_pkg::entry_t  head,
  output pmf_pkg::q_stat_t stat
);
  import pmf_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

### rtl/core/pmf_back.sv
// Back end: walks the head entry one byte a cycle into the output register, stalling while a held result is not taken.
// Depends on pmf_pkg and pmf_rsp_if.
module pmf_back (
  input  logic            clk,
  input  logic            rst,
  input  pmf_pkg::entry_t head,
  input  logic            q_empty,
  output logic            pop,
  pmf_rsp_if.source       rsp
);
  import pmf_pkg::*;

  logic [BIDX_W-1:0] idx;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_last;
  logic              out_status;
  logic              load;
  logic              take;
  logic              at_end;

  assign load   = !out_valid || rsp.ready;
  assign take   = load && !q_empty;
  assign at_end = (idx == head.last_idx);
  assign pop    = take && at_end;

  assign rsp.valid    = out_valid;
  assign rsp.out_byte = out_byte;
  assign rsp.last     = out_last;
  assign rsp.status   = out_status;

  // Advance the byte index within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (take) begin
      idx       <= at_end ? '0 : idx + 1'b1;
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte   <= head.data[idx];
      out_last   <= head.mark_last && at_end;
      out_status <= head.status;
    end
  end

endmodule

### rtl/core/mqtt_publish_framer_unit.sv
// Top level of the PUBLISH packet framer: front end, entry queue, back end.
// Depends on pmf_pkg, pmf_req_if, pmf_rsp_if, pmf_cfg_if and the three submodules.
//
// Turns a header request and the topic and message bytes that follow into the
// serialized PUBLISH packet, one byte per result, the last one flagged; a
// packet larger than max_packet_bytes gives one result with status set
// instead. A request is taken whenever the four-entry queue between front and
// back has room, so body bytes stream in and out at one per cycle while the
// result channel keeps up. The output register moves one byte per cycle while
// its results are taken: a header request yields four to eight bytes, or one
// when too large, while the queue lets up to three further requests be taken
// meanwhile. On an idle block a request's first result passes through a queue
// slot and then the output register. Configuration writes are taken in any cycle.
module mqtt_publish_framer_unit (
  input logic       clk,
  input logic       rst,
  pmf_req_if.sink   req,
  pmf_rsp_if.source rsp,
  pmf_cfg_if.sink   cfg
);
  import pmf_pkg::*;

  logic    push;
  entry_t  push_entry;
  logic    pop;
  entry_t  head;
  q_stat_t q_stat;

  pmf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .q_full     (q_stat.full),
    .push       (push),
    .push_entry (push_entry)
  );

  pmf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  pmf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_stat.empty),
    .pop     (pop),
    .rsp     (rsp)
  );

  // Error result is a lone, flagged, zero byte
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_TOO_BIG) |-> (rsp.last && rsp.out_byte == 8'd0))
    else $error("too-large result not a lone flagged zero byte");

  // Queue fill never passes its depth
  assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("entry queue overfilled");

  // A full queue stops requests and nothing is pushed into it
  assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> (!req.ready && !push))
    else $error("request taken while queue full");

  // No result is shown right after reset
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !rsp.valid)
    else $error("result valid right after reset");

endmodule
